>>> sv/eda_pkg.sv
package eda_pkg;

  localparam int FEAT_W = 16;
  localparam int DIFF_W = FEAT_W + 1;
  localparam int MAG_W  = FEAT_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 39;
  localparam int RAD_W  = SUM_W + 1;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DIST_W = 20;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_SAT = 20'h80000;

  // One word travelling down the square-root chain
  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } root_word_t;

endpackage

>>> sv/eda_accum.sv
module eda_accum #(
  parameter int MAX_FEATURES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [eda_pkg::FEAT_W-1:0]  feature_a,
  input  logic signed [eda_pkg::FEAT_W-1:0]  feature_b,
  input  logic                               last_feature,
  output eda_pkg::root_word_t                word_out
);

  localparam int CNT_W = $clog2(MAX_FEATURES + 1);

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          keep;
  logic signed [eda_pkg::DIFF_W-1:0] diff;
  logic [eda_pkg::DIFF_W-1:0]    diff_abs;
  logic [eda_pkg::MAG_W-1:0]     mag;
  logic [eda_pkg::SQ_W-1:0]      sq;

  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic                          s1_keep_r;
  logic [eda_pkg::SQ_W-1:0]      s1_sq_r;

  logic [eda_pkg::SUM_W-1:0]     sum_r;
  logic                          ovf_r;
  logic [eda_pkg::RAD_W-1:0]     sum_add;
  logic [eda_pkg::SUM_W-1:0]     sum_nxt;
  logic                          ovf_nxt;
  eda_pkg::root_word_t           word_r;

  assign keep = count_r < CNT_W'(MAX_FEATURES);

  always_comb begin
    diff     = eda_pkg::DIFF_W'(feature_a) - eda_pkg::DIFF_W'(feature_b);
    diff_abs = diff[eda_pkg::DIFF_W-1] ? -diff : diff;
    mag      = diff_abs[eda_pkg::MAG_W-1:0];
    sq       = mag * mag;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_valid) begin
      if (last_feature) begin
        count_nxt = '0;
      end else if (keep) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else if (en) begin
      count_r    <= count_nxt;
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r <= last_feature;
      s1_keep_r <= keep;
      s1_sq_r   <= sq;
    end
  end

  // Add with clamp; a pair past the limit is dropped and flags the sum
  always_comb begin
    sum_add = {1'b0, sum_r} + eda_pkg::RAD_W'(s1_sq_r);
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (!s1_keep_r) begin
      ovf_nxt = 1'b1;
    end else if (sum_add[eda_pkg::RAD_W-1]) begin
      sum_nxt = eda_pkg::SUM_MAX;
      ovf_nxt = 1'b1;
    end else begin
      sum_nxt = sum_add[eda_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else if (en && s1_valid_r) begin
      if (s1_last_r) begin
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r.valid <= s1_valid_r & s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.sat  <= ovf_nxt;
      word_r.rem  <= '0;
      word_r.root <= '0;
      word_r.rad  <= {1'b0, sum_nxt};
    end
  end

  assign word_out = word_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && s1_valid_r && s1_last_r |=> sum_r == '0 && !ovf_r)
    else $error("sum not cleared after last pair");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FEATURES))
    else $error("feature count past limit");
`endif

endmodule

>>> sv/eda_sqrt_cell.sv
module eda_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  eda_pkg::root_word_t word_in,
  output eda_pkg::root_word_t word_out
);

  logic [eda_pkg::REM_W+1:0] rem_sh;
  logic [eda_pkg::REM_W+1:0] trial;
  logic [eda_pkg::REM_W+1:0] diff;
  eda_pkg::root_word_t       word_nxt;
  eda_pkg::root_word_t       word_r;

  // One root bit: bring down two radicand bits, try (4*root + 1)
  always_comb begin
    rem_sh   = {word_in.rem, word_in.rad[eda_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, word_in.root, 2'b01};
    diff     = rem_sh - trial;
    word_nxt = word_in;
    word_nxt.rad = {word_in.rad[eda_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      word_nxt.rem  = diff[eda_pkg::REM_W-1:0];
      word_nxt.root = {word_in.root[eda_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      word_nxt.rem  = rem_sh[eda_pkg::REM_W-1:0];
      word_nxt.root = {word_in.root[eda_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r.valid <= word_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.sat  <= word_nxt.sat;
      word_r.rem  <= word_nxt.rem;
      word_r.root <= word_nxt.root;
      word_r.rad  <= word_nxt.rad;
    end
  end

  assign word_out = word_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    en && word_in.valid |=> word_out.rem <= {word_out.root, 1'b0})
    else $error("square-root remainder above twice the root");
`endif

endmodule

>>> sv/euclidean_distance_accumulator_top.sv
// Euclidean distance accumulator. Feed one feature pair (signed Q8.8) per word and mark
// the final pair with in_last_feature; the block sums the squared differences and
// returns floor(sqrt(sum)) as an unsigned Q12.8 distance on the result channel. Only
// marked words give a result. Pairs beyond MAX_FEATURES are dropped, and any such
// pair, or a clamped sum, sets out_saturated and forces out_distance to 524288.
// A pair is taken every cycle while in_ready is high. After the last pair is taken, the
// distance passes through the squaring stage, which the pair lands in at its accepting
// edge, then one accumulate stage, a chain of 20 root cells that each settle one bit of
// the root, and the output register. The input stalls only when the last root cell
// holds a distance while the output register is still full.
module euclidean_distance_accumulator_top #(
  parameter int MAX_FEATURES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [eda_pkg::FEAT_W-1:0]  in_feature_a,
  input  logic signed [eda_pkg::FEAT_W-1:0]  in_feature_b,
  input  logic                               in_last_feature,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [eda_pkg::DIST_W-1:0]         out_distance,
  output logic                               out_saturated
);

  eda_pkg::root_word_t         chain [0:eda_pkg::ROOT_W];
  eda_pkg::root_word_t         tail;
  logic                        en;
  logic                        out_valid_r;
  logic [eda_pkg::DIST_W-1:0]  distance_r;
  logic [eda_pkg::DIST_W-1:0]  distance_nxt;
  logic                        saturated_r;

  assign tail     = chain[eda_pkg::ROOT_W];
  assign en       = !tail.valid || !out_valid_r || out_ready;
  assign in_ready = en;

  eda_accum #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .feature_a    (in_feature_a),
    .feature_b    (in_feature_b),
    .last_feature (in_last_feature),
    .word_out     (chain[0])
  );

  for (genvar i = 0; i < eda_pkg::ROOT_W; i++) begin : g_cell
    eda_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

  always_comb begin
    if (tail.sat || tail.root > eda_pkg::DIST_SAT) begin
      distance_nxt = eda_pkg::DIST_SAT;
    end else begin
      distance_nxt = tail.root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail.valid && en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid && en) begin
      distance_r  <= distance_nxt;
      saturated_r <= tail.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = distance_r;
  assign out_saturated = saturated_r;

`ifndef SYNTHESIS
  a_sat_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_distance == eda_pkg::DIST_SAT)
    else $error("saturated word without full-scale distance");
  a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= eda_pkg::DIST_SAT)
    else $error("distance above full scale");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> tail.valid && out_valid_r && !out_ready)
    else $error("input stalled without a blocked distance");
`endif

endmodule

>>> tb/dist_checker.sv
`timescale 1ns / 1ps

module dist_checker #(
  parameter int MAX_FEATURES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [eda_pkg::FEAT_W-1:0] in_feature_a,
  input  logic signed [eda_pkg::FEAT_W-1:0] in_feature_b,
  input  logic                              in_last_feature,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [eda_pkg::DIST_W-1:0]        out_distance,
  input  logic                              out_saturated,
  output int                                mismatches,
  output int                                distances_due
);

  typedef struct packed {
    logic [eda_pkg::DIST_W-1:0] distance;
    logic                       saturated;
  } dist_result_t;

  dist_result_t              due_q[$];
  logic [eda_pkg::SUM_W-1:0] sq_sum;
  int unsigned               pair_cnt;
  logic                      clamp_seen;

  initial begin
    mismatches    = 0;
    distances_due = 0;
    sq_sum        = '0;
    pair_cnt      = 0;
    clamp_seen    = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: distance mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Floor root, one bit at a time from the top
  function automatic logic [eda_pkg::DIST_W-1:0] floor_root(
      input logic [eda_pkg::SUM_W-1:0] v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = eda_pkg::DIST_W - 1; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= {25'd0, v}) r = trial;
    end
    return r[eda_pkg::DIST_W-1:0];
  endfunction

  task automatic accumulate_pair(input logic signed [eda_pkg::FEAT_W-1:0] a,
                                 input logic signed [eda_pkg::FEAT_W-1:0] b,
                                 input logic last);
    logic signed [eda_pkg::FEAT_W:0] diff;
    logic [eda_pkg::FEAT_W-1:0]      mag;
    logic [2*eda_pkg::FEAT_W-1:0]    sq;
    logic [eda_pkg::DIST_W-1:0]      root;
    dist_result_t                    res;
    if (pair_cnt >= MAX_FEATURES) begin
      clamp_seen = 1'b1;
    end else begin
      diff = $signed({a[eda_pkg::FEAT_W-1], a}) - $signed({b[eda_pkg::FEAT_W-1], b});
      mag  = diff[eda_pkg::FEAT_W] ? eda_pkg::FEAT_W'(-diff) : diff[eda_pkg::FEAT_W-1:0];
      sq   = mag * mag;
      if ({7'd0, sq} > eda_pkg::SUM_MAX - sq_sum) begin
        sq_sum     = eda_pkg::SUM_MAX;
        clamp_seen = 1'b1;
      end else begin
        sq_sum = sq_sum + {7'd0, sq};
      end
      pair_cnt++;
    end
    if (last) begin
      if (clamp_seen) begin
        res.distance  = eda_pkg::DIST_SAT;
        res.saturated = 1'b1;
      end else begin
        root          = floor_root(sq_sum);
        res.distance  = (root > eda_pkg::DIST_SAT) ? eda_pkg::DIST_SAT : root;
        res.saturated = 1'b0;
      end
      due_q.push_back(res);
      sq_sum     = '0;
      pair_cnt   = 0;
      clamp_seen = 1'b0;
    end
  endtask

  // Output side first, so a word taken this edge never meets its own prediction
  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result distance=%0d saturated=%0b",
                                    out_distance, out_saturated));
        end else begin
          want = due_q.pop_front();
          if (out_distance !== want.distance)
            report_mismatch($sformatf("distance got %0d, want %0d",
                                      out_distance, want.distance));
          if (out_saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %0b, want %0b",
                                      out_saturated, want.saturated));
        end
      end
      if (in_valid && in_ready)
        accumulate_pair(in_feature_a, in_feature_b, in_last_feature);
      distances_due = due_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_PAIRS  = 64;
  localparam int WORD_COUNT = 1350;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [eda_pkg::FEAT_W-1:0] in_feature_a;
  logic signed [eda_pkg::FEAT_W-1:0] in_feature_b;
  logic                              in_last_feature;
  logic                              out_valid;
  logic                              out_ready;
  logic [eda_pkg::DIST_W-1:0]        out_distance;
  logic                              out_saturated;
  int                                mismatches;
  int                                distances_due;
  int                                words_sent;
  int                                tx_calm;

  euclidean_distance_accumulator_top #(
    .MAX_FEATURES (MAX_PAIRS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_feature_a    (in_feature_a),
    .in_feature_b    (in_feature_b),
    .in_last_feature (in_last_feature),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance    (out_distance),
    .out_saturated   (out_saturated)
  );

  dist_checker #(
    .MAX_FEATURES (MAX_PAIRS)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_feature_a    (in_feature_a),
    .in_feature_b    (in_feature_b),
    .in_last_feature (in_last_feature),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance    (out_distance),
    .out_saturated   (out_saturated),
    .mismatches      (mismatches),
    .distances_due   (distances_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Idle cycles before the next word; now and then a calm stretch with none
  task automatic draw_wait(inout int calm, output int n);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 40);
      n = $urandom_range(0, 13);
    end
  endtask

  task automatic send_word(input logic signed [eda_pkg::FEAT_W-1:0] a,
                           input logic signed [eda_pkg::FEAT_W-1:0] b,
                           input logic last);
    int gap;
    draw_wait(tx_calm, gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_feature_a    <= a;
    in_feature_b    <= b;
    in_last_feature <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    words_sent++;
  endtask

  function automatic logic signed [eda_pkg::FEAT_W-1:0] pick_feature();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return $signed(eda_pkg::FEAT_W'($urandom_range(0, 65535)));
  endfunction

  // Widest spread on every pair when flat_out is set
  task automatic send_point_pair(input int len, input bit flat_out);
    for (int i = 0; i < len; i++) begin
      if (flat_out) send_word(16'sh7FFF, 16'sh8000, i == len - 1);
      else          send_word(pick_feature(), pick_feature(), i == len - 1);
    end
  endtask

  // Result side: each word waits its own stall before ready rises
  initial begin
    int rx_calm;
    int stall;
    rx_calm = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      draw_wait(rx_calm, stall);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int len;
    int pick;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_feature_a    = '0;
    in_feature_b    = '0;
    in_last_feature = 1'b0;
    words_sent      = 0;
    tx_calm         = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-pair points at the field extremes
    send_word(16'sh7FFF, 16'sh8000, 1'b1);
    send_word(16'sh8000, 16'sh7FFF, 1'b1);
    send_word(16'sh0000, 16'sh0000, 1'b1);
    send_word(16'shFFFF, 16'sh0000, 1'b1);
    send_word(16'sh8000, 16'sh8000, 1'b1);
    send_word(16'sh0001, 16'shFFFF, 1'b1);
    // Short point, then the largest sum without saturation, then one pair too many
    send_word(16'sh0100, 16'sh0000, 1'b0);
    send_word(16'sh0000, 16'sh0100, 1'b0);
    send_word(16'sh5555, 16'shAAAA, 1'b1);
    send_point_pair(MAX_PAIRS, 1'b1);
    send_point_pair(MAX_PAIRS + 1, 1'b0);
    send_word(16'sh0003, 16'sh0007, 1'b1);

    while (words_sent < WORD_COUNT) begin
      pick = $urandom_range(0, 24);
      case (pick)
        0:       len = $urandom_range(MAX_PAIRS - 4, MAX_PAIRS + 6);
        1:       len = MAX_PAIRS + $urandom_range(0, 1);
        default: len = $urandom_range(1, 12);
      endcase
      send_point_pair(len, pick < 2 && $urandom_range(0, 1) == 1);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (distances_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
sv/eda_pkg.sv
sv/eda_accum.sv
sv/eda_sqrt_cell.sv
sv/euclidean_distance_accumulator_top.sv
tb/dist_checker.sv
tb/tb_top.sv
